// File: src/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, disabled during reset.
`define ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Property that must hold at each rising clock edge at which the enable is high.
`define ASSERT_WHEN(label, en, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (en) |-> (cond)) \
      else $error(msg);

`endif

// File: src/fewa_pkg.sv
// ----------------------------------------------------------------------------
// fewa_pkg
// Types and codes shared by the flash erase block wear allocator.
// ----------------------------------------------------------------------------
package fewa_pkg;

   // operation codes
   localparam logic [2:0] OP_SET_STATE = 3'd0;
   localparam logic [2:0] OP_PREPARE   = 3'd1;
   localparam logic [2:0] OP_ALLOC_WR  = 3'd2;
   localparam logic [2:0] OP_ALLOC_LVL = 3'd3;
   localparam logic [2:0] OP_RETIRE    = 3'd4;
   localparam logic [2:0] OP_WRITE_OFF = 3'd5;

   // block state codes
   localparam logic [2:0] BS_UNKNOWN = 3'd0;
   localparam logic [2:0] BS_FREE    = 3'd1;
   localparam logic [2:0] BS_BAD     = 3'd2;
   localparam logic [2:0] BS_WORN    = 3'd3;

   // header status codes
   localparam logic [1:0] HS_READABLE = 2'd0;
   localparam logic [1:0] HS_BLANK    = 2'd1;

   // result status codes
   localparam logic [1:0] RS_OK         = 2'd0;
   localparam logic [1:0] RS_NO_SPACE   = 2'd1;
   localparam logic [1:0] RS_AT_LIMIT   = 2'd2;
   localparam logic [1:0] RS_NEEDS_PREP = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_BLOCK_COUNT = 2'd0;
   localparam logic [1:0] CSR_WEAR_THRESH = 2'd1;
   localparam logic [1:0] CSR_PROT_CYCLES = 2'd2;
   localparam logic [1:0] CSR_MAX_ERASE   = 2'd3;

   // mean computation: sum of up to 256 31-bit counts, divisor up to 256
   localparam int SUM_W     = 40;
   localparam int DIV_STEPS = SUM_W;

   typedef struct packed {
      logic [2:0]  operation;
      logic [7:0]  block;
      logic [2:0]  new_state;
      logic [1:0]  header_status;
      logic [31:0] header_erase_count;
      logic        protect_after;
      logic [31:0] volume_id;
      logic [31:0] logical_block;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  chosen_block;
      logic [30:0] new_erase_count;
      logic        bad_event;
      logic [31:0] event_volume;
      logic [31:0] event_logical;
      logic [2:0]  block_state;
   } rsp_type;

endpackage

// File: src/flash_erase_block_wear_allocator.sv
// ----------------------------------------------------------------------------
// flash_erase_block_wear_allocator
// Per-block state, erase count and protection countdown with wear-leveled
// allocation, all scans done by one sequencer over block memories.
// ----------------------------------------------------------------------------
//  channel  dir  handshake            payload
//  req      in   req_valid/req_stall  req_payload (req_type)
//  rsp      out  rsp_valid/rsp_stall  rsp_payload (rsp_type)
//  csr      in   csr_valid/csr_ready  csr_index, csr_wdata
//
//  After reset a clearing pass zeroes every entry of the memories.
//  Set state, retire, write off: state written in decode, then the result;
//  undefined operations read the block's state in a lookup and check step.
//  Prepare: lookup, check, then a countdown scan of the n blocks in use; a
//  header neither readable nor blank first adds a mean scan and serial divide.
//  Allocate: up to two scans of the block memory.
//  One entry is read per cycle through the single memory read port; a stalled
//  result is held while the next transaction is taken in and processed.
`include "assert_macros.svh"

module flash_erase_block_wear_allocator import fewa_pkg::*; #(
   parameter int MAX_BLOCKS = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_payload,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int IDX_W = $clog2(MAX_BLOCKS);
   localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_DECODE = 4'd2;
   localparam logic [3:0] S_MEAN   = 4'd3;
   localparam logic [3:0] S_DIV    = 4'd4;
   localparam logic [3:0] S_LOOKUP = 4'd5;
   localparam logic [3:0] S_CHECK  = 4'd6;
   localparam logic [3:0] S_TICK   = 4'd7;
   localparam logic [3:0] S_LFREE  = 4'd8;
   localparam logic [3:0] S_HFREE  = 4'd9;
   localparam logic [3:0] S_LUNK   = 4'd10;
   localparam logic [3:0] S_DONE   = 4'd11;

   // configuration
   logic [8:0]  block_count_ff, block_count_in;
   logic [29:0] wear_thresh_ff, wear_thresh_in;
   logic [7:0]  prot_cycles_ff, prot_cycles_in;
   logic [30:0] max_erase_ff, max_erase_in;

   // sequencer
   logic [3:0]       state_ff, state_in;
   req_type          req_ff, req_in;
   rsp_type          res_ff, res_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0] scan_addr_ff, scan_addr_in;
   logic             dv_ff, dv_in;
   logic [IDX_W-1:0] didx_ff, didx_in;
   logic             found_ff, found_in;
   logic [30:0]      low_ff, low_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [31:0]      ceil_ff, ceil_in;
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [8:0]       counted_ff, counted_in;
   logic [31:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0] quo_ff, quo_in;
   logic [9:0]       rem_ff, rem_in;
   logic [5:0]       div_cnt_ff, div_cnt_in;

   // block memories
   logic [2:0]  st_mem [MAX_BLOCKS];
   logic [30:0] cnt_mem [MAX_BLOCKS];
   logic [7:0]  cd_mem [MAX_BLOCKS];
   logic [2:0]  rd_st_ff;
   logic [30:0] rd_cnt_ff;
   logic [7:0]  rd_cd_ff;

   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic             st_we, cnt_we, cd_we;
   logic [2:0]       st_wd;
   logic [30:0]      cnt_wd;
   logic [7:0]       cd_wd;

   logic [CNT_W-1:0] live_n;
   logic             in_range, issue, scan_done, is_scan, rsp_free;
   logic [IDX_W-1:0] blk_ix;
   logic [9:0]       rem_shift;
   logic             div_bit;
   logic [SUM_W-1:0] quo_next;
   logic [31:0]      span;

   assign csr_ready   = 1'b1;
   assign req_stall   = (state_ff != S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;
   assign rsp_free    = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (16'(block_count_ff) < 16'(MAX_BLOCKS)) begin
         live_n = CNT_W'(block_count_ff);
      end else begin
         live_n = CNT_W'(MAX_BLOCKS);
      end
   end

   assign in_range  = 16'(req_ff.block) < 16'(live_n);
   assign blk_ix    = IDX_W'(req_ff.block);
   assign issue     = scan_addr_ff < live_n;
   assign scan_done = !issue && !dv_ff;
   assign is_scan   = (state_ff == S_MEAN) || (state_ff == S_TICK) ||
                      (state_ff == S_LFREE) || (state_ff == S_HFREE) ||
                      (state_ff == S_LUNK);
   assign rd_addr   = is_scan ? scan_addr_ff[IDX_W-1:0] : blk_ix;

   // restoring divider step
   assign rem_shift = {rem_ff[8:0], quo_ff[SUM_W-1]};
   assign div_bit   = rem_shift >= {1'b0, counted_ff};
   assign quo_next  = {quo_ff[SUM_W-2:0], div_bit};

   assign span = (req_ff.operation == OP_ALLOC_LVL) ? {1'b0, wear_thresh_ff, 1'b0}
                                                     : {2'b00, wear_thresh_ff};

   always_comb begin
      block_count_in = block_count_ff;
      wear_thresh_in = wear_thresh_ff;
      prot_cycles_in = prot_cycles_ff;
      max_erase_in   = max_erase_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_BLOCK_COUNT: block_count_in = csr_wdata[8:0];
            CSR_WEAR_THRESH: wear_thresh_in = csr_wdata[29:0];
            CSR_PROT_CYCLES: prot_cycles_in = csr_wdata[7:0];
            CSR_MAX_ERASE:   max_erase_in   = csr_wdata[30:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      scan_addr_in = scan_addr_ff;
      dv_in        = 1'b0;
      didx_in      = didx_ff;
      found_in     = found_ff;
      low_in       = low_ff;
      idx_in       = idx_ff;
      ceil_in      = ceil_ff;
      sum_in       = sum_ff;
      counted_in   = counted_ff;
      cnt_in       = cnt_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      wr_addr      = blk_ix;
      st_we        = 1'b0;
      cnt_we       = 1'b0;
      cd_we        = 1'b0;
      st_wd        = BS_UNKNOWN;
      cnt_wd       = '0;
      cd_wd        = '0;

      if (is_scan) begin
         if (issue) begin
            scan_addr_in = scan_addr_ff + 1'b1;
         end
         dv_in   = issue;
         didx_in = scan_addr_ff[IDX_W-1:0];
      end

      case (state_ff)
         S_CLEAR: begin
            wr_addr      = scan_addr_ff[IDX_W-1:0];
            st_we        = 1'b1;
            cnt_we       = 1'b1;
            cd_we        = 1'b1;
            scan_addr_in = scan_addr_ff + 1'b1;
            if (scan_addr_ff == CNT_W'(MAX_BLOCKS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               req_in   = req_payload;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            res_in.status          = RS_OK;
            res_in.chosen_block    = req_ff.block;
            res_in.new_erase_count = '0;
            res_in.bad_event       = 1'b0;
            res_in.event_volume    = '0;
            res_in.event_logical   = '0;
            res_in.block_state     = BS_UNKNOWN;
            scan_addr_in           = '0;
            found_in               = 1'b0;
            sum_in                 = '0;
            counted_in             = '0;
            if (req_ff.operation == OP_ALLOC_WR || req_ff.operation == OP_ALLOC_LVL) begin
               state_in = S_LFREE;
            end else if (!in_range) begin
               state_in = S_DONE;
            end else begin
               case (req_ff.operation)
                  OP_SET_STATE: begin
                     st_we              = 1'b1;
                     st_wd              = req_ff.new_state;
                     res_in.block_state = req_ff.new_state;
                     state_in           = S_DONE;
                  end
                  OP_RETIRE: begin
                     st_we                = 1'b1;
                     st_wd                = BS_BAD;
                     res_in.block_state   = BS_BAD;
                     res_in.bad_event     = 1'b1;
                     res_in.event_volume  = req_ff.volume_id;
                     res_in.event_logical = req_ff.logical_block;
                     state_in             = S_DONE;
                  end
                  OP_WRITE_OFF: begin
                     st_we              = 1'b1;
                     st_wd              = BS_WORN;
                     res_in.block_state = BS_WORN;
                     state_in           = S_DONE;
                  end
                  OP_PREPARE: begin
                     if (req_ff.header_status == HS_READABLE) begin
                        cnt_in   = req_ff.header_erase_count;
                        state_in = S_LOOKUP;
                     end else if (req_ff.header_status == HS_BLANK) begin
                        cnt_in   = '0;
                        state_in = S_LOOKUP;
                     end else begin
                        state_in = S_MEAN;
                     end
                  end
                  // undefined operation: only report the block's state
                  default: state_in = S_LOOKUP;
               endcase
            end
         end
         S_MEAN: begin
            if (dv_ff && rd_st_ff != BS_UNKNOWN && rd_st_ff != BS_BAD &&
                rd_st_ff != BS_WORN) begin
               sum_in     = sum_ff + SUM_W'(rd_cnt_ff);
               counted_in = counted_ff + 1'b1;
            end
            if (scan_done) begin
               if (counted_ff == '0) begin
                  cnt_in   = '0;
                  state_in = S_LOOKUP;
               end else begin
                  quo_in     = sum_ff;
                  rem_in     = '0;
                  div_cnt_in = '0;
                  state_in   = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in = div_bit ? (rem_shift - {1'b0, counted_ff}) : rem_shift;
            quo_in = quo_next;
            if (div_cnt_ff == 6'(DIV_STEPS - 1)) begin
               cnt_in   = quo_next[31:0];
               state_in = S_LOOKUP;
            end else begin
               div_cnt_in = div_cnt_ff + 1'b1;
            end
         end
         S_LOOKUP: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (req_ff.operation != OP_PREPARE) begin
               res_in.block_state = rd_st_ff;
               state_in           = S_DONE;
            end else if (cnt_ff >= {1'b0, max_erase_ff}) begin
               res_in.status      = RS_AT_LIMIT;
               res_in.block_state = rd_st_ff;
               state_in           = S_DONE;
            end else begin
               cnt_we                 = 1'b1;
               cnt_wd                 = cnt_ff[30:0] + 31'd1;
               st_we                  = 1'b1;
               st_wd                  = BS_FREE;
               res_in.new_erase_count = cnt_ff[30:0] + 31'd1;
               res_in.block_state     = BS_FREE;
               scan_addr_in           = '0;
               state_in               = S_TICK;
            end
         end
         S_TICK: begin
            // age every countdown, reload the prepared block's own
            wr_addr = didx_ff;
            if (dv_ff) begin
               cd_we = 1'b1;
               if (didx_ff == blk_ix) begin
                  cd_wd = req_ff.protect_after ? prot_cycles_ff : 8'd0;
               end else if (rd_cd_ff != 8'd0) begin
                  cd_wd = rd_cd_ff - 8'd1;
               end
            end
            if (scan_done) begin
               state_in = S_DONE;
            end
         end
         S_LFREE: begin
            if (dv_ff && rd_st_ff == BS_FREE && (!found_ff || rd_cnt_ff < low_ff)) begin
               found_in = 1'b1;
               low_in   = rd_cnt_ff;
               idx_in   = didx_ff;
            end
            if (scan_done) begin
               scan_addr_in = '0;
               if (found_ff) begin
                  ceil_in  = {1'b0, low_ff} + span;
                  state_in = S_HFREE;
               end else if (req_ff.operation == OP_ALLOC_WR) begin
                  state_in = S_LUNK;
               end else begin
                  res_in.status       = RS_NO_SPACE;
                  res_in.chosen_block = '0;
                  state_in            = S_DONE;
               end
            end
         end
         S_HFREE: begin
            // low_ff tracks the highest count found below the ceiling
            if (dv_ff && rd_st_ff == BS_FREE && {1'b0, rd_cnt_ff} < ceil_ff &&
                rd_cnt_ff > low_ff) begin
               low_in = rd_cnt_ff;
               idx_in = didx_ff;
            end
            if (scan_done) begin
               res_in.chosen_block = 8'(idx_ff);
               res_in.block_state  = BS_FREE;
               if (req_ff.operation == OP_ALLOC_WR) begin
                  wr_addr = idx_ff;
                  cd_we   = 1'b1;
                  cd_wd   = prot_cycles_ff;
               end
               state_in = S_DONE;
            end
         end
         S_LUNK: begin
            if (dv_ff && rd_st_ff == BS_UNKNOWN && (!found_ff || rd_cnt_ff < low_ff)) begin
               found_in = 1'b1;
               low_in   = rd_cnt_ff;
               idx_in   = didx_ff;
            end
            if (scan_done) begin
               res_in.block_state = BS_UNKNOWN;
               if (found_ff) begin
                  res_in.status       = RS_NEEDS_PREP;
                  res_in.chosen_block = 8'(idx_ff);
               end else begin
                  res_in.status       = RS_NO_SPACE;
                  res_in.chosen_block = '0;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (rsp_free) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_count_ff <= 9'd256;
         wear_thresh_ff <= 30'd4096;
         prot_cycles_ff <= 8'd10;
         max_erase_ff   <= 31'h7FFF_FFFF;
         state_ff       <= S_CLEAR;
         rsp_valid_ff   <= 1'b0;
         scan_addr_ff   <= '0;
         dv_ff          <= 1'b0;
      end else begin
         block_count_ff <= block_count_in;
         wear_thresh_ff <= wear_thresh_in;
         prot_cycles_ff <= prot_cycles_in;
         max_erase_ff   <= max_erase_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
         scan_addr_ff   <= scan_addr_in;
         dv_ff          <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
      didx_ff    <= didx_in;
      found_ff   <= found_in;
      low_ff     <= low_in;
      idx_ff     <= idx_in;
      ceil_ff    <= ceil_in;
      sum_ff     <= sum_in;
      counted_ff <= counted_in;
      cnt_ff     <= cnt_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      div_cnt_ff <= div_cnt_in;
   end

   always_ff @(posedge clock) begin
      if (st_we) begin
         st_mem[wr_addr] <= st_wd;
      end
      if (cnt_we) begin
         cnt_mem[wr_addr] <= cnt_wd;
      end
      if (cd_we) begin
         cd_mem[wr_addr] <= cd_wd;
      end
      rd_st_ff  <= st_mem[rd_addr];
      rd_cnt_ff <= cnt_mem[rd_addr];
      rd_cd_ff  <= cd_mem[rd_addr];
   end

   `ASSERT_CLK(a_accept_decodes, (req_valid && !req_stall) |=> (state_ff == S_DECODE), "accepted transaction not decoded")
   `ASSERT_WHEN(a_clear_no_rsp, state_ff == S_CLEAR, !rsp_valid_ff, "result valid during clearing pass")
   `ASSERT_WHEN(a_div_bound, state_ff == S_DIV, div_cnt_ff < 6'(DIV_STEPS), "divider step count overrun")
   `ASSERT_WHEN(a_scan_in_range, dv_ff, 16'(didx_ff) < 16'(live_n), "scan index beyond blocks in use")

endmodule
